// File: hw/rtl/kwm_pkg.sv
// Shared types, defaults and helpers for the k-way record merge.
// Used by kwm_order_cmp and k_way_record_merge under hw/rtl; depends on nothing else.
package kwm_pkg;

    // Default sizing, handed down as top-level parameter defaults
    localparam int WAYS_DEF        = 64;
    localparam int COLOR_WORDS_DEF = 4;

    // Fixed payload widths
    localparam int WORD_W      = 64;
    localparam int WAY_W       = 6;
    localparam int ACTIVE_W    = 7;
    localparam int MAX_COLORS  = 4;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 7'd64;

    // Request command codes
    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_EXHAUST = 1'b1;

    // One input request
    typedef struct packed {
        logic              command;
        logic [WAY_W-1:0]  way;
        logic [WORD_W-1:0] minimizer;
        logic [WORD_W-1:0] color_word_0;
        logic [WORD_W-1:0] color_word_1;
        logic [WORD_W-1:0] color_word_2;
        logic [WORD_W-1:0] color_word_3;
    } item_t;

    // One merged result
    typedef struct packed {
        logic [WORD_W-1:0] out_minimizer;
        logic [WORD_W-1:0] out_color_0;
        logic [WORD_W-1:0] out_color_1;
        logic [WORD_W-1:0] out_color_2;
        logic [WORD_W-1:0] out_color_3;
        logic [WAY_W-1:0]  source_way;
        logic              done_res;
    } res_t;

    // Byte swap: little-endian memory order becomes a plain unsigned key
    function automatic logic [WORD_W-1:0] byte_rev(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < 8; b++)
        begin
            r[8*(7-b) +: 8] = x[8*b +: 8];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the head records of the merge; no dependencies.
module kwm_ram #(
    parameter int WIDTH = 320,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/kwm_order_cmp.sv
// Record ordering unit: colours as little-endian bytes first, then minimizer.
// Depends on kwm_pkg for widths and the byte swap helper.
module kwm_order_cmp #(
    parameter int COLOR_WORDS = kwm_pkg::COLOR_WORDS_DEF
) (
    input  logic [kwm_pkg::WORD_W*(COLOR_WORDS+1)-1:0] a_word,
    input  logic [kwm_pkg::WORD_W*(COLOR_WORDS+1)-1:0] b_word,
    output logic                                       a_less
);

    localparam int W     = kwm_pkg::WORD_W;
    localparam int KEY_W = W * (COLOR_WORDS + 1);

    logic [KEY_W-1:0] a_key;
    logic [KEY_W-1:0] b_key;

    // Key: colour 0 most significant, minimizer least significant
    assign a_key[W-1:0] = a_word[W-1:0];
    assign b_key[W-1:0] = b_word[W-1:0];

    for (genvar c = 0; c < COLOR_WORDS; c++)
    begin : g_key
        assign a_key[W*(COLOR_WORDS-c) +: W] = kwm_pkg::byte_rev(a_word[W*(c+1) +: W]);
        assign b_key[W*(COLOR_WORDS-c) +: W] = kwm_pkg::byte_rev(b_word[W*(c+1) +: W]);
    end

    // One wide unsigned compare
    assign a_less = (a_key < b_key);

endmodule

// File: hw/rtl/k_way_record_merge.sv
// K-way record merge: top level with sequencer, head flags and output register.
// Depends on kwm_pkg, kwm_ram and kwm_order_cmp.
//
// Usage
//   item channel (item_valid / item_stall): one request per record or per
//   exhausted way. item_stall is high while a request is in work.
//   res channel (res_valid / res_stall): at most one result per request, the
//   smallest head record with its source way, or a single done marker.
//   cfg channel (cfg_valid / cfg_ready): writes active_ways; always ready.
// Sequencing (n = active way count clamped to 1..WAYS)
//   A request that leaves an active way without a head goes from CHECK back to
//   IDLE; a done marker goes from CHECK to EMIT, where it is registered.
//   Otherwise the one comparator walks the head RAM a way per cycle in SCAN
//   over n ways, then the record is registered in EMIT and the next request is
//   taken back in IDLE; the head RAM read port sets this pace.
// Reset
//   rst_n clears all head valid and exhausted flags, the done marker and the
//   output valid flag; active_ways returns to 64. No RAM clearing pass is run.
// Back-pressure
//   A result waits in the output register while res_stall is high; the next
//   request is still taken and worked on, and holds only at the final load
//   until the output register frees up.
module k_way_record_merge #(
    parameter int WAYS        = kwm_pkg::WAYS_DEF,
    parameter int COLOR_WORDS = kwm_pkg::COLOR_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  kwm_pkg::item_t                 item,
    output logic                           res_valid,
    input  logic                           res_stall,
    output kwm_pkg::res_t                  res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kwm_pkg::ACTIVE_W-1:0]   cfg_data
);

    localparam int W      = kwm_pkg::WORD_W;
    localparam int AW     = $clog2(WAYS);
    localparam int NW     = $clog2(WAYS + 1);
    localparam int XW     = (NW > kwm_pkg::ACTIVE_W) ? NW : kwm_pkg::ACTIVE_W;
    localparam int CW     = (NW > kwm_pkg::WAY_W) ? NW : kwm_pkg::WAY_W;
    localparam int RAM_W  = W * (COLOR_WORDS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // Registers
    state_t                        state_reg,      state_next;
    logic [kwm_pkg::ACTIVE_W-1:0]  active_reg;
    logic [WAYS-1:0]               head_valid_reg, head_valid_next;
    logic [WAYS-1:0]               way_exh_reg,    way_exh_next;
    logic                          done_sent_reg,  done_sent_next;
    logic [NW-1:0]                 issue_reg,      issue_next;
    logic                          cmp_pend_reg,   cmp_pend_next;
    logic [AW-1:0]                 cmp_idx_reg,    cmp_idx_next;
    logic                          have_best_reg,  have_best_next;
    logic [AW-1:0]                 best_idx_reg,   best_idx_next;
    logic [RAM_W-1:0]              best_word_reg,  best_word_next;
    logic                          emit_done_reg,  emit_done_next;
    logic                          res_valid_reg,  res_valid_next;
    kwm_pkg::res_t                 res_reg,        res_next;

    // Combinational
    logic [NW-1:0]    eff_n;
    logic [XW-1:0]    active_ext;
    logic [WAYS-1:0]  way_mask;
    logic             heads_ready;
    logic             any_head;
    logic             all_exh;
    logic [CW-1:0]    item_way_ext;
    logic [AW-1:0]    item_addr;
    logic             way_hit;
    logic             accept;
    logic             ram_wr_en;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic             rd_less;
    logic             take;
    logic [W-1:0]     item_col [kwm_pkg::MAX_COLORS];
    logic [W-1:0]     best_col [kwm_pkg::MAX_COLORS];
    logic [CW-1:0]    best_idx_ext;

    // Effective way count, clamped to 1..WAYS
    assign active_ext = XW'(active_reg);
    always_comb
    begin
        if (active_ext == '0)
        begin
            eff_n = NW'(1);
        end
        else if (active_ext > XW'(WAYS))
        begin
            eff_n = NW'(WAYS);
        end
        else
        begin
            eff_n = active_ext[NW-1:0];
        end
    end

    for (genvar i = 0; i < WAYS; i++)
    begin : g_mask
        assign way_mask[i] = (NW'(i) < eff_n);
    end

    // Emission conditions over the active ways
    assign heads_ready = &(head_valid_reg | way_exh_reg | ~way_mask);
    assign any_head    = |(head_valid_reg & way_mask);
    assign all_exh     = &(way_exh_reg | ~way_mask);

    // Request decode
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign item_way_ext = CW'(item.way);
    assign item_addr    = item_way_ext[AW-1:0];
    assign way_hit      = (item_way_ext < CW'(eff_n));
    assign ram_wr_en    = accept && way_hit && (item.command == kwm_pkg::CMD_RECORD)
                          && !way_exh_reg[item_addr];

    assign item_col[0] = item.color_word_0;
    assign item_col[1] = item.color_word_1;
    assign item_col[2] = item.color_word_2;
    assign item_col[3] = item.color_word_3;

    assign ram_wdata[W-1:0] = item.minimizer;
    for (genvar c = 0; c < COLOR_WORDS; c++)
    begin : g_wdata
        assign ram_wdata[W*(c+1) +: W] = item_col[c];
    end

    // Head store
    kwm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WAYS)
    ) u_heads (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (item_addr),
        .wr_data (ram_wdata),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Shared ordering unit: fetched head against best so far
    kwm_order_cmp #(
        .COLOR_WORDS (COLOR_WORDS)
    ) u_cmp (
        .a_word (ram_rdata),
        .b_word (best_word_reg),
        .a_less (rd_less)
    );

    assign take = cmp_pend_reg && head_valid_reg[cmp_idx_reg] && (!have_best_reg || rd_less);

    // Result fields from the best head
    for (genvar c = 0; c < kwm_pkg::MAX_COLORS; c++)
    begin : g_bcol
        if (c < COLOR_WORDS)
        begin : g_used
            assign best_col[c] = best_word_reg[W*(c+1) +: W];
        end
        else
        begin : g_unused
            assign best_col[c] = '0;
        end
    end
    assign best_idx_ext = CW'(best_idx_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        way_exh_next    = way_exh_reg;
        done_sent_next  = done_sent_reg;
        issue_next      = issue_reg;
        cmp_pend_next   = cmp_pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        have_best_next  = have_best_reg;
        best_idx_next   = best_idx_reg;
        best_word_next  = best_word_reg;
        emit_done_next  = emit_done_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;

        // Output register drains
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (way_hit)
                    begin
                        if (item.command == kwm_pkg::CMD_EXHAUST)
                        begin
                            way_exh_next[item_addr] = 1'b1;
                        end
                        else if (!way_exh_reg[item_addr])
                        begin
                            head_valid_next[item_addr] = 1'b1;
                        end
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (!heads_ready)
                begin
                    state_next = ST_IDLE;
                end
                else if (any_head)
                begin
                    issue_next     = '0;
                    cmp_pend_next  = 1'b0;
                    have_best_next = 1'b0;
                    emit_done_next = 1'b0;
                    state_next     = ST_SCAN;
                end
                else if (all_exh && !done_sent_reg)
                begin
                    emit_done_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // Compare the head fetched last cycle
                if (take)
                begin
                    best_word_next = ram_rdata;
                    best_idx_next  = cmp_idx_reg;
                    have_best_next = 1'b1;
                end
                // Fetch the next way, or finish once the last compare is in
                if (issue_reg < eff_n)
                begin
                    issue_next    = issue_reg + NW'(1);
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = issue_reg[AW-1:0];
                end
                else
                begin
                    cmp_pend_next = 1'b0;
                    if (!cmp_pend_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    if (emit_done_reg)
                    begin
                        res_next          = '0;
                        res_next.done_res = 1'b1;
                        done_sent_next    = 1'b1;
                    end
                    else
                    begin
                        res_next.out_minimizer = best_word_reg[W-1:0];
                        res_next.out_color_0   = best_col[0];
                        res_next.out_color_1   = best_col[1];
                        res_next.out_color_2   = best_col[2];
                        res_next.out_color_3   = best_col[3];
                        res_next.source_way    = best_idx_ext[kwm_pkg::WAY_W-1:0];
                        res_next.done_res      = 1'b0;
                        head_valid_next[best_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= kwm_pkg::ACTIVE_RST;
            head_valid_reg <= '0;
            way_exh_reg    <= '0;
            done_sent_reg  <= 1'b0;
            issue_reg      <= '0;
            cmp_pend_reg   <= 1'b0;
            have_best_reg  <= 1'b0;
            emit_done_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            way_exh_reg    <= way_exh_next;
            done_sent_reg  <= done_sent_next;
            issue_reg      <= issue_next;
            cmp_pend_reg   <= cmp_pend_next;
            have_best_reg  <= have_best_next;
            emit_done_reg  <= emit_done_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_word_reg <= best_word_next;
        res_reg       <= res_next;
    end

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: dv/k_way_record_merge_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for k_way_record_merge: directed and random merge requests,
// checked against an in-bench model of the head store. Depends on kwm_pkg and the RTL.
module k_way_record_merge_tb;

    localparam int NWAYS         = kwm_pkg::WAYS_DEF;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_stall;
    kwm_pkg::item_t               item_bus;
    logic                         res_valid;
    logic                         res_stall;
    kwm_pkg::res_t                res_bus;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [kwm_pkg::ACTIVE_W-1:0] cfg_data;

    // Model of the head store and the merge setting
    logic [kwm_pkg::WORD_W-1:0]   slot_min [NWAYS];
    logic [kwm_pkg::WORD_W-1:0]   slot_col [NWAYS][kwm_pkg::MAX_COLORS];
    bit                           slot_full [NWAYS];
    bit                           way_dry [NWAYS];
    bit                           done_given;
    logic [kwm_pkg::ACTIVE_W-1:0] active_setting;

    kwm_pkg::res_t                merged_q[$];
    kwm_pkg::res_t                want_res;
    int                           err_count;
    int                           cycles;
    int                           send_idle_pct;
    int                           recv_idle_pct;
    int                           retired_ways;

    k_way_record_merge i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item_bus),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res_bus),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("k_way_record_merge_tb: FAIL");
            $finish;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic int active_count();
        int a;
        a = active_setting;
        if (a < 1) a = 1;
        if (a > NWAYS) a = NWAYS;
        return a;
    endfunction

    // Head a goes before head b: colour bytes in memory order, then minimiser
    function automatic bit ranks_first(input int a, input int b);
        logic [7:0] xa;
        logic [7:0] xb;
        for (int c = 0; c < kwm_pkg::MAX_COLORS; c++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                xa = slot_col[a][c][8*j +: 8];
                xb = slot_col[b][c][8*j +: 8];
                if (xa != xb) return xa < xb;
            end
        end
        return slot_min[a] < slot_min[b];
    endfunction

    // Apply one accepted request and queue the merged record or done marker
    task automatic predict_merge(input kwm_pkg::item_t req);
        int            n;
        int            best;
        bit            ready;
        bit            found;
        bit            all_dry;
        kwm_pkg::res_t r;
        n       = active_count();
        best    = 0;
        ready   = 1'b1;
        found   = 1'b0;
        all_dry = 1'b1;
        if (req.way < n)
        begin
            if (req.command == kwm_pkg::CMD_EXHAUST)
                way_dry[req.way] = 1'b1;
            else if (!way_dry[req.way])
            begin
                slot_min[req.way]    = req.minimizer;
                slot_col[req.way][0] = req.color_word_0;
                slot_col[req.way][1] = req.color_word_1;
                slot_col[req.way][2] = req.color_word_2;
                slot_col[req.way][3] = req.color_word_3;
                slot_full[req.way]   = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (!slot_full[i] && !way_dry[i]) ready = 1'b0;
            if (!way_dry[i]) all_dry = 1'b0;
            if (slot_full[i])
            begin
                if (!found || ranks_first(i, best)) best = i;
                found = 1'b1;
            end
        end
        if (!ready) return;
        r = '0;
        if (found)
        begin
            r.out_minimizer = slot_min[best];
            r.out_color_0   = slot_col[best][0];
            r.out_color_1   = slot_col[best][1];
            r.out_color_2   = slot_col[best][2];
            r.out_color_3   = slot_col[best][3];
            r.source_way    = best[kwm_pkg::WAY_W-1:0];
            slot_full[best] = 1'b0;
            merged_q = {merged_q, r};
        end
        else if (all_dry && !done_given)
        begin
            done_given = 1'b1;
            r.done_res = 1'b1;
            merged_q = {merged_q, r};
        end
    endtask

    task automatic report_field(input string fname, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (merged_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: result with none expected: %h", $time, res_bus);
            end
            else
            begin
                want_res = merged_q.pop_front();
                report_field("out_minimizer", want_res.out_minimizer, res_bus.out_minimizer);
                report_field("out_color_0", want_res.out_color_0, res_bus.out_color_0);
                report_field("out_color_1", want_res.out_color_1, res_bus.out_color_1);
                report_field("out_color_2", want_res.out_color_2, res_bus.out_color_2);
                report_field("out_color_3", want_res.out_color_3, res_bus.out_color_3);
                report_field("source_way", 64'(want_res.source_way), 64'(res_bus.source_way));
                report_field("done_res", 64'(want_res.done_res), 64'(res_bus.done_res));
            end
        end
    end

    // Drive one request and wait for it to be taken
    task automatic send_request(input kwm_pkg::item_t req);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        item_bus   <= req;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        predict_merge(req);
    endtask

    // Hold requests off until every expected result is out and the block is quiet
    task automatic wait_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (merged_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_active(input logic [kwm_pkg::ACTIVE_W-1:0] val);
        @(negedge clk);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        active_setting = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic kwm_pkg::item_t make_record(input int w, input logic [63:0] mn,
                                                   input logic [63:0] c0,
                                                   input logic [63:0] c1,
                                                   input logic [63:0] c2,
                                                   input logic [63:0] c3);
        kwm_pkg::item_t req;
        req.command      = kwm_pkg::CMD_RECORD;
        req.way          = w[kwm_pkg::WAY_W-1:0];
        req.minimizer    = mn;
        req.color_word_0 = c0;
        req.color_word_1 = c1;
        req.color_word_2 = c2;
        req.color_word_3 = c3;
        return req;
    endfunction

    function automatic kwm_pkg::item_t make_exhaust(input int w);
        kwm_pkg::item_t req;
        req         = make_record(w, '1, '1, '1, '1, '1);
        req.command = kwm_pkg::CMD_EXHAUST;
        return req;
    endfunction

    // Key words biased towards ties and single-byte differences
    function automatic logic [63:0] pick_word();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'($urandom_range(0, 3));
            3:
            begin
                v = '0;
                v[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(0, 3));
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic kwm_pkg::item_t random_record(input int w);
        return make_record(w, pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
    endfunction

    // An active way that still needs a head, searched from a random start
    function automatic int find_empty_way(input int n);
        int start;
        int w;
        start = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++)
        begin
            w = (start + k) % n;
            if (!slot_full[w] && !way_dry[w]) return w;
        end
        return -1;
    endfunction

    // Mostly refills of the way that was just drained, the rest overwrites and noise
    function automatic kwm_pkg::item_t next_merge_request();
        int             n;
        int             r;
        int             w;
        kwm_pkg::item_t req;
        n = active_count();
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            w = find_empty_way(n);
            if (w < 0) w = $urandom_range(0, n - 1);
            req = random_record(w);
        end
        else if (r < 90)
            req = random_record($urandom_range(0, n - 1));
        else if (r < 94 && n > 40 && retired_ways < 12)
        begin
            req = random_record($urandom_range(40, n - 1));
            req.command = kwm_pkg::CMD_EXHAUST;
        end
        else if (n < NWAYS)
        begin
            req = random_record($urandom_range(n, NWAYS - 1));
            req.command = 1'($urandom);
        end
        else
            req = random_record($urandom_range(0, NWAYS - 1));
        return req;
    endfunction

    task automatic run_merge_session(input logic [kwm_pkg::ACTIVE_W-1:0] val, input int count);
        kwm_pkg::item_t req;
        wait_drain();
        program_active(val);
        for (int k = 0; k < count; k++)
        begin
            // one full pause mid-session so the pipe empties completely
            if (k == count / 2) wait_drain();
            req = next_merge_request();
            if (req.command == kwm_pkg::CMD_EXHAUST && req.way < active_count()
                && !way_dry[req.way])
                retired_ways++;
            send_request(req);
        end
    endtask

    // Reset setting, field extremes and out-of-range ways with one way active
    task automatic test_single_way();
        send_request(make_record(63, 64'h5a5a, '0, '1, '0, '1));
        wait_drain();
        program_active(7'd0);
        send_request(make_record(0, '0, '0, '0, '0, '0));
        send_request(make_record(0, '1, '1, '1, '1, '1));
        send_request(make_record(63, '1, '1, '1, '1, '1));
        send_request(make_record(1, 64'h1, 64'h2, 64'h3, 64'h4, 64'h5));
        send_request(make_record(0, 64'h8000_0000_0000_0000, 64'h0123_4567_89ab_cdef,
                                 64'hfedc_ba98_7654_3210, 64'haaaa_5555_aaaa_5555,
                                 64'h5555_aaaa_5555_aaaa));
    endtask

    // Byte order of colours, minimiser tie-break, lowest way on equal keys, overwrite
    task automatic test_key_order();
        wait_drain();
        program_active(7'd2);
        send_request(make_record(1, 64'd5, 64'h01, '0, '0, '0));
        send_request(make_record(0, 64'd1, 64'h0100_0000_0000_0000, '0, '0, '0));
        send_request(make_record(0, 64'd5, 64'h01, '0, '0, '0));
        send_request(make_record(0, 64'd4, 64'h01, '0, '0, '0));
        send_request(make_record(0, 64'd0, 64'h01, 64'h0200, '0, '0));
        send_request(make_record(1, 64'd9, 64'h01, 64'h0100, '0, 64'hff));
        // way 0 head replaced while way 1 is still empty
        send_request(make_record(0, '1, 64'h01, 64'h0200, 64'h0300, '0));
        send_request(make_record(1, '0, 64'h01, 64'h0200, 64'h0300, 64'h01));
    endtask

    // Exhaust with a head held, record to an exhausted way, ignored exhaust
    task automatic test_exhaust_rules();
        wait_drain();
        program_active(7'd3);
        send_request(make_record(2, '0, '0, '0, '0, '0));
        send_request(make_exhaust(2));
        send_request(make_record(0, 64'd3, 64'h8000, '0, '0, '0));
        send_request(make_record(2, 64'd7, 64'h7, 64'h7, 64'h7, 64'h7));
        send_request(make_exhaust(5));
    endtask

    task automatic test_random_merge(input int s_pct, input int r_pct,
                                     input logic [kwm_pkg::ACTIVE_W-1:0] cfg_a,
                                     input logic [kwm_pkg::ACTIVE_W-1:0] cfg_b,
                                     input logic [kwm_pkg::ACTIVE_W-1:0] cfg_c);
        wait_drain();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        run_merge_session(cfg_a, 122);
        run_merge_session(cfg_b, 122);
        run_merge_session(cfg_c, 122);
    endtask

    // Last head leaves as exhaustion completes, so done follows one request later;
    // done is then not repeated
    task automatic test_end_of_merge();
        kwm_pkg::item_t kick;
        kick = make_record(63, '0, '0, '0, '0, '0);
        wait_drain();
        program_active(7'd3);
        // leave way 1 holding the largest key and way 0 empty
        for (int k = 0; k < 20; k++)
        begin
            if (!slot_full[1])
                send_request(make_record(1, '1, '1, '1, '1, '1));
            else if (slot_full[0])
                send_request(kick);
            else
                break;
        end
        send_request(make_exhaust(1));
        send_request(make_exhaust(0));
        repeat (4) send_request(kick);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item_bus       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        res_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        err_count      = 0;
        cycles         = 0;
        retired_ways   = 0;
        done_given     = 1'b0;
        active_setting = kwm_pkg::ACTIVE_RST;
        for (int i = 0; i < NWAYS; i++)
        begin
            slot_full[i] = 1'b0;
            way_dry[i]   = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 65;
        test_single_way();
        test_key_order();
        test_exhaust_rules();
        test_random_merge(19, 65, 7'd127, 7'd4, 7'd32);
        test_random_merge(65, 19, 7'd64, 7'd9, 7'd1);
        test_end_of_merge();
        test_random_merge(0, 0, 7'd100, 7'd16, 7'd8);
        wait_drain();

        if (err_count == 0)
            $display("k_way_record_merge_tb: PASS");
        else
            $display("k_way_record_merge_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ram.sv
hw/rtl/kwm_order_cmp.sv
hw/rtl/k_way_record_merge.sv
dv/k_way_record_merge_tb.sv
